[hw/rtl/cartridge_rom_checksum_defines.svh]
// Assertion helpers shared by the checksum RTL.
`ifndef CARTRIDGE_ROM_CHECKSUM_DEFINES_SVH
`define CARTRIDGE_ROM_CHECKSUM_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CRC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define CRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever ante holds, cons must hold in the next cycle.
`define CRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/crc_pkg.sv]
package crc_pkg;

   typedef struct packed {
      logic        command;
      logic [31:0] data_word;
      logic        last;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] checksum_one;
      logic [31:0] checksum_two;
      logic [2:0]  variant;
      logic [31:0] boot_crc;
   } rsp_payload_type;

   localparam logic CMD_BOOT     = 1'b0;
   localparam logic CMD_CHECKSUM = 1'b1;

   localparam logic [2:0] VAR_6101 = 3'd0;
   localparam logic [2:0] VAR_6102 = 3'd1;
   localparam logic [2:0] VAR_6103 = 3'd2;
   localparam logic [2:0] VAR_6105 = 3'd3;
   localparam logic [2:0] VAR_6106 = 3'd4;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [31:0] SIG_6101 = 32'h6170A4A1;
   localparam logic [31:0] SIG_6102 = 32'h90BB6CB5;
   localparam logic [31:0] SIG_6103 = 32'h0B050EE0;
   localparam logic [31:0] SIG_6105 = 32'h98BC2C86;
   localparam logic [31:0] SIG_6106 = 32'hACC8580A;

   localparam logic [31:0] SEED_6102 = 32'hF8CA4DDC;
   localparam logic [31:0] SEED_6103 = 32'hA3886759;
   localparam logic [31:0] SEED_6105 = 32'hDF26F436;
   localparam logic [31:0] SEED_6106 = 32'h1FEA617A;

   // Captured boot words sit at byte offsets 0x750..0x84F; boot words are
   // counted from byte offset 0x40, which puts the window at word 0x710 / 4.
   localparam int          SAMPLE_WORDS = 64;
   localparam int          SAMPLE_AW    = 6;
   localparam logic [31:0] SAMPLE_FIRST = 32'h710 / 4;
   localparam logic [31:0] SAMPLE_END   = SAMPLE_FIRST + 32'(SAMPLE_WORDS);

   localparam logic [4:0] ROT_MASK = 5'h1F;

   // Reflected CRC-32 over one word, most significant byte first.
   function automatic logic [31:0] crc32_word(input logic [31:0] crc_in,
                                              input logic [31:0] word);
      logic [31:0] c;
      c = crc_in;
      for (int b = 3; b >= 0; b--) begin
         c = c ^ {24'd0, word[8*b +: 8]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   function automatic logic [2:0] pick_variant(input logic [31:0] sig);
      logic [2:0] v;
      case (sig)
         SIG_6101: v = VAR_6101;
         SIG_6102: v = VAR_6102;
         SIG_6103: v = VAR_6103;
         SIG_6105: v = VAR_6105;
         SIG_6106: v = VAR_6106;
         default:  v = VAR_6105;
      endcase
      return v;
   endfunction

   // The 6101 boot code shares the 6102 seed.
   function automatic logic [31:0] seed_of(input logic [2:0] v);
      logic [31:0] s;
      case (v)
         VAR_6103: s = SEED_6103;
         VAR_6105: s = SEED_6105;
         VAR_6106: s = SEED_6106;
         default:  s = SEED_6102;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] w;
      w = {v, v} << s;
      return w[63:32];
   endfunction

endpackage

[hw/rtl/cartridge_rom_checksum.sv]
// Channel  | Direction | Handshake             | Payload
// req_     | in        | req_valid / req_stall | req_data: command, data_word, last
// rsp_     | out       | rsp_valid / rsp_stall | rsp_data: checksum_one, checksum_two,
//          |           |                       |           variant, boot_crc
//
// One transaction is accepted per cycle unless a waiting last word stalls input.
// The result of the last checksum word is formed by the state update, the
// combining multiply or XOR, and the final add or XOR, each registered in turn.
// Sample memory is read as a checksum word is accepted and used at its state update.
// Reset is synchronous and clears the sums at once; the sample memory is not cleared.
// A stalled result does not block input unless a last word finds the three
// result registers full; that word then waits and holds the input back.
`include "cartridge_rom_checksum_defines.svh"

module cartridge_rom_checksum
   import crc_pkg::*;
#(
   parameter int BOOT_WORDS = 1008
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int CNT_W = $clog2(BOOT_WORDS + 1);

   typedef struct packed {
      logic [31:0] plain;
      logic [31:0] carry;
      logic [31:0] acc_three;
      logic [31:0] rot;
      logic [31:0] acc_two;
      logic [31:0] acc_one;
      logic [2:0]  variant;
      logic [31:0] crc;
   } fin_type;

   typedef struct packed {
      logic [31:0] one_a;
      logic [31:0] one_b;
      logic [31:0] two_a;
      logic [31:0] two_b;
      logic        use_add;
      logic [2:0]  variant;
      logic [31:0] crc;
   } comb_type;

   // Sample memory and its registered read port.
   logic [31:0]          sample_mem [SAMPLE_WORDS];
   logic [31:0]          s1_sample_ff;
   logic                 mem_we;
   logic [SAMPLE_AW-1:0] mem_waddr;
   logic                 mem_re;

   // Accepted word waiting for the state update.
   logic                 s1_valid_ff, s1_valid_in;
   req_payload_type      s1_item_ff;
   logic [SAMPLE_AW-1:0] word_addr_ff, word_addr_in;

   // Running state.
   logic [31:0]          crc_ff, crc_in;
   logic [CNT_W-1:0]     boot_count_ff, boot_count_in;
   logic                 started_ff, started_in;
   logic [2:0]           variant_ff, variant_in;
   logic [31:0]          acc_one_ff, acc_one_in;
   logic [31:0]          acc_two_ff, acc_two_in;
   logic [31:0]          acc_three_ff, acc_three_in;
   logic [31:0]          carry_ff, carry_in;
   logic [31:0]          rot_ff, rot_in;
   logic [31:0]          plain_ff, plain_in;

   // Result pipeline.
   logic                 fin_valid_ff, fin_valid_in;
   fin_type              fin_ff, fin_in;
   logic                 prod_valid_ff, prod_valid_in;
   comb_type             prod_ff, prod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 s1_take;
   logic                 s1_is_end;
   logic                 fin_load;
   logic                 out_ready;
   logic                 prod_ready;
   logic                 fin_ready;
   logic                 boot_active;
   logic                 in_window;
   logic [31:0]          boot_count_ext;
   logic [31:0]          d;
   logic [2:0]           variant_sel;
   logic [31:0]          seed;
   logic [31:0]          plain_b, carry_b, acc_three_b, rot_b, acc_two_b, acc_one_b;
   logic [32:0]          sum33;
   logic [31:0]          plain_n, carry_n, acc_three_n, rot_n, acc_two_n, acc_one_n;
   logic [31:0]          rot_word;

   // Handshake and pipeline flow.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign fin_ready  = !fin_valid_ff || prod_ready;
   assign s1_is_end  = (s1_item_ff.command == CMD_CHECKSUM) && s1_item_ff.last;
   assign s1_take    = s1_valid_ff && (!s1_is_end || fin_ready);
   assign req_stall  = s1_valid_ff && !s1_take;
   assign accept     = req_valid && !req_stall;
   assign fin_load   = s1_take && s1_is_end;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_take);
   assign word_addr_in = (accept && req_data.command == CMD_CHECKSUM) ?
                         (req_data.last ? '0 : word_addr_ff + 1'b1) : word_addr_ff;

   // Boot word handling.
   assign d              = s1_item_ff.data_word;
   assign boot_count_ext = 32'(boot_count_ff);
   assign boot_active    = (s1_item_ff.command == CMD_BOOT) && !started_ff &&
                           (boot_count_ff < CNT_W'(BOOT_WORDS));
   assign in_window      = (boot_count_ext >= SAMPLE_FIRST) && (boot_count_ext < SAMPLE_END);
   assign mem_we         = s1_take && boot_active && in_window;
   assign mem_waddr      = SAMPLE_AW'(boot_count_ext - SAMPLE_FIRST);
   assign mem_re         = accept && (req_data.command == CMD_CHECKSUM);

   // Checksum word handling; the first word of a run starts from the seed.
   assign variant_sel = started_ff ? variant_ff : pick_variant(~crc_ff);
   assign seed        = seed_of(variant_sel);
   assign plain_b     = started_ff ? plain_ff     : seed;
   assign carry_b     = started_ff ? carry_ff     : seed;
   assign acc_three_b = started_ff ? acc_three_ff : seed;
   assign rot_b       = started_ff ? rot_ff       : seed;
   assign acc_two_b   = started_ff ? acc_two_ff   : seed;
   assign acc_one_b   = started_ff ? acc_one_ff   : seed;

   assign sum33       = {1'b0, plain_b} + {1'b0, d};
   assign plain_n     = sum33[31:0];
   assign carry_n     = carry_b + 32'(sum33[32]);
   assign acc_three_n = acc_three_b ^ d;
   assign rot_word    = rotl32(d, d[4:0] & ROT_MASK);
   assign rot_n       = rot_b + rot_word;
   assign acc_two_n   = (acc_two_b > d) ? (acc_two_b ^ rot_word) : (acc_two_b ^ plain_n ^ d);
   assign acc_one_n   = acc_one_b + ((variant_sel == VAR_6105) ? (s1_sample_ff ^ d)
                                                              : (rot_n ^ d));

   always_comb begin
      crc_in        = crc_ff;
      boot_count_in = boot_count_ff;
      started_in    = started_ff;
      variant_in    = variant_ff;
      plain_in      = plain_ff;
      carry_in      = carry_ff;
      acc_three_in  = acc_three_ff;
      rot_in        = rot_ff;
      acc_two_in    = acc_two_ff;
      acc_one_in    = acc_one_ff;
      if (s1_take) begin
         if (s1_item_ff.command == CMD_BOOT) begin
            if (boot_active) begin
               crc_in        = crc32_word(crc_ff, d);
               boot_count_in = boot_count_ff + 1'b1;
            end
         end else if (s1_item_ff.last) begin
            crc_in        = CRC_INIT;
            boot_count_in = '0;
            started_in    = 1'b0;
            variant_in    = VAR_6101;
            plain_in      = '0;
            carry_in      = '0;
            acc_three_in  = '0;
            rot_in        = '0;
            acc_two_in    = '0;
            acc_one_in    = '0;
         end else begin
            started_in    = 1'b1;
            variant_in    = variant_sel;
            plain_in      = plain_n;
            carry_in      = carry_n;
            acc_three_in  = acc_three_n;
            rot_in        = rot_n;
            acc_two_in    = acc_two_n;
            acc_one_in    = acc_one_n;
         end
      end
   end

   assign fin_valid_in = fin_load || (fin_valid_ff && !prod_ready);
   always_comb begin
      fin_in           = fin_ff;
      if (fin_load) begin
         fin_in.plain     = plain_n;
         fin_in.carry     = carry_n;
         fin_in.acc_three = acc_three_n;
         fin_in.rot       = rot_n;
         fin_in.acc_two   = acc_two_n;
         fin_in.acc_one   = acc_one_n;
         fin_in.variant   = variant_sel;
         fin_in.crc       = ~crc_ff;
      end
   end

   // The 6106 form multiplies here; the add or XOR follows in the next stage.
   assign prod_valid_in = (fin_valid_ff && prod_ready) || (prod_valid_ff && !out_ready);
   always_comb begin
      prod_in = prod_ff;
      if (fin_valid_ff && prod_ready) begin
         if (fin_ff.variant == VAR_6106) begin
            prod_in.one_a = 32'(fin_ff.plain * fin_ff.carry);
            prod_in.two_a = 32'(fin_ff.rot * fin_ff.acc_two);
         end else begin
            prod_in.one_a = fin_ff.plain ^ fin_ff.carry;
            prod_in.two_a = fin_ff.rot ^ fin_ff.acc_two;
         end
         prod_in.one_b   = fin_ff.acc_three;
         prod_in.two_b   = fin_ff.acc_one;
         prod_in.use_add = (fin_ff.variant == VAR_6103) || (fin_ff.variant == VAR_6106);
         prod_in.variant = fin_ff.variant;
         prod_in.crc     = fin_ff.crc;
      end
   end

   assign rsp_valid_in = (prod_valid_ff && out_ready) || (rsp_valid_ff && rsp_stall);
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (prod_valid_ff && out_ready) begin
         rsp_data_in.checksum_one = prod_ff.use_add ? (prod_ff.one_a + prod_ff.one_b)
                                                    : (prod_ff.one_a ^ prod_ff.one_b);
         rsp_data_in.checksum_two = prod_ff.use_add ? (prod_ff.two_a + prod_ff.two_b)
                                                    : (prod_ff.two_a ^ prod_ff.two_b);
         rsp_data_in.variant      = prod_ff.variant;
         rsp_data_in.boot_crc     = prod_ff.crc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A read that meets a write to the same entry takes the new data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_waddr] <= d;
      end
      if (mem_re) begin
         if (mem_we && mem_waddr == word_addr_ff) begin
            s1_sample_ff <= d;
         end else begin
            s1_sample_ff <= sample_mem[word_addr_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         word_addr_ff  <= '0;
         crc_ff        <= CRC_INIT;
         boot_count_ff <= '0;
         started_ff    <= 1'b0;
         variant_ff    <= VAR_6101;
         plain_ff      <= '0;
         carry_ff      <= '0;
         acc_three_ff  <= '0;
         rot_ff        <= '0;
         acc_two_ff    <= '0;
         acc_one_ff    <= '0;
         fin_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         word_addr_ff  <= word_addr_in;
         crc_ff        <= crc_in;
         boot_count_ff <= boot_count_in;
         started_ff    <= started_in;
         variant_ff    <= variant_in;
         plain_ff      <= plain_in;
         carry_ff      <= carry_in;
         acc_three_ff  <= acc_three_in;
         rot_ff        <= rot_in;
         acc_two_ff    <= acc_two_in;
         acc_one_ff    <= acc_one_in;
         fin_valid_ff  <= fin_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
      fin_ff      <= fin_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   `CRC_ASSERT_IMPLY(a_stall_only_on_end, clock, reset, req_stall, s1_valid_ff && s1_is_end, "input stalled without a waiting last checksum word")
   `CRC_ASSERT_NEXT(a_end_clears_run, clock, reset, fin_load, !started_ff && boot_count_ff == '0 && crc_ff == CRC_INIT, "run state not cleared after the last checksum word")
   `CRC_ASSERT_ALWAYS(a_boot_count_bound, clock, reset, boot_count_ff <= CNT_W'(BOOT_WORDS), "boot word count beyond the boot code length")
   `CRC_ASSERT_NEXT(a_sample_forward, clock, reset, mem_re && mem_we && mem_waddr == word_addr_ff, s1_sample_ff == $past(d), "sample read missed a write to the same entry")

endmodule
